FILE: src/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg: shared types and constants for the quaternion to Euler unit
// Arctangent table, work format sizes and the sqrt/CORDIC cell payload types.
// ----------------------------------------------------------------------------
package q2e_pkg;

    // work format: 30 fraction bits; operands reach 2^34.5, CORDIC gain adds 0.72 bit
    localparam int WORK_FRAC  = 30;
    localparam int WW         = 38;     // work word, signed
    localparam int ZW         = 26;     // angle accumulator, 2^24 per turn
    localparam int ATAN_LEN   = 24;
    localparam int SQW        = 62;     // sqrt radicand width

    typedef logic signed [WW-1:0] t_work;
    typedef logic signed [ZW-1:0] t_ang;

    localparam t_ang QUARTER_TURN = t_ang'(26'sd4194304);

    // one CORDIC lane: vector and accumulated angle
    typedef struct packed {
        t_work x;
        t_work y;
        t_ang  z;
    } t_lane;

    // arctangent of 2^-i, 2^24 per turn
    function automatic t_ang atan_tab(input logic [4:0] i);
        t_ang r;
        case (i)
            5'd0:  r = 26'sd2097152;
            5'd1:  r = 26'sd1238021;
            5'd2:  r = 26'sd654136;
            5'd3:  r = 26'sd332050;
            5'd4:  r = 26'sd166669;
            5'd5:  r = 26'sd83416;
            5'd6:  r = 26'sd41718;
            5'd7:  r = 26'sd20860;
            5'd8:  r = 26'sd10430;
            5'd9:  r = 26'sd5215;
            5'd10: r = 26'sd2608;
            5'd11: r = 26'sd1304;
            5'd12: r = 26'sd652;
            5'd13: r = 26'sd326;
            5'd14: r = 26'sd163;
            5'd15: r = 26'sd81;
            5'd16: r = 26'sd41;
            5'd17: r = 26'sd20;
            5'd18: r = 26'sd10;
            5'd19: r = 26'sd5;
            5'd20: r = 26'sd3;
            5'd21: r = 26'sd1;
            5'd22: r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

    // atan2 lane preset: zero angle, left half plane rotation
    function automatic t_lane lane_init(input t_work y, input t_work x);
        t_lane l;
        l.x = x;
        l.y = y;
        l.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                l.x = y;
                l.y = -x;
                l.z = QUARTER_TURN;
            end else begin
                l.x = -y;
                l.y = x;
                l.z = -QUARTER_TURN;
            end
        end
        return l;
    endfunction

    // final rounding to a 16 bit binary angle
    function automatic logic [15:0] angle16(input t_ang z);
        t_ang t;
        t = z + t_ang'(128);
        return t[23:8];
    endfunction

endpackage

FILE: src/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring micro-rotation, registered
// Turns the vector toward the x axis by atan(2^-STEP) and tracks the angle.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  q2e_pkg::t_lane i_lane,
    output q2e_pkg::t_lane o_lane
);
    import q2e_pkg::*;

    t_lane n_lane;
    t_lane r_lane;

    // micro-rotation with floor shifts
    always_comb begin
        n_lane = i_lane;
        if (i_lane.y >= 0) begin
            n_lane.x = i_lane.x + (i_lane.y >>> STEP);
            n_lane.y = i_lane.y - (i_lane.x >>> STEP);
            n_lane.z = i_lane.z + atan_tab(5'(STEP));
        end else begin
            n_lane.x = i_lane.x - (i_lane.y >>> STEP);
            n_lane.y = i_lane.y + (i_lane.x >>> STEP);
            n_lane.z = i_lane.z - atan_tab(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

FILE: src/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell: one digit of a restoring integer square root, registered
// Handles radicand bit pair BIT and carries the sine along for pitch.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
    parameter int BIT = 30
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [q2e_pkg::SQW-1:0]    i_rem,
    input  logic [q2e_pkg::SQW-1:0]    i_res,
    input  q2e_pkg::t_work             i_s,
    output logic [q2e_pkg::SQW-1:0]    o_rem,
    output logic [q2e_pkg::SQW-1:0]    o_res,
    output q2e_pkg::t_work             o_s
);
    import q2e_pkg::*;

    localparam logic [SQW-1:0] ONE_BIT = SQW'(1) << (2 * BIT);

    logic [SQW-1:0] n_rem, n_res, trial;
    logic [SQW-1:0] r_rem, r_res;
    t_work          r_s;

    // classic digit-by-digit step; leading skip is equivalent when bit > v
    always_comb begin
        trial = i_res + ONE_BIT;
        if (i_rem >= trial) begin
            n_rem = i_rem - trial;
            n_res = (i_res >> 1) + ONE_BIT;
        end else begin
            n_rem = i_rem;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_s   <= i_s;
        end
    end

    assign o_rem = r_rem;
    assign o_res = r_res;
    assign o_s   = r_s;
endmodule

FILE: src/quaternion_to_euler_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit: Q2.14 quaternion to ZYX roll, pitch, yaw
// Products, pitch square root cells and three CORDIC cell chains.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis takes one quaternion request per cycle; tdata packs
//   qw, qx, qy, qz from the lowest bit up. Master channel m_axis gives roll,
//   pitch, yaw (16 bit binary angles, 65536 per turn) from the lowest bit up.
//   Throughput is one request per cycle unless the output stalls. The path
//   is two product stages, 31 square root digit cells for the pitch
//   cosine, then one cell per CORDIC step and an output register.
//   All stages advance together; when the receiver holds m_axis_tready low
//   with a result waiting, the whole chain halts and s_axis_tready drops, so
//   nothing is lost. Reset clears the valid bits only; data is not reset.
//   CORDIC_STEPS above 24 acts as 24.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit #(
    parameter int CORDIC_STEPS    = 16,
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [4*COMPONENT_WIDTH-1:0] s_axis_tdata,  // qw, qx, qy, qz
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [47:0]                  m_axis_tdata   // roll, pitch, yaw
);
    import q2e_pkg::*;

    localparam int CW     = COMPONENT_WIDTH;
    localparam int NSTEP  = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int SH     = 2 * (CW - 2) - WORK_FRAC;
    localparam int PW     = 2 * CW;
    localparam int NSQ    = 31;
    localparam int DEPTH  = 3 + NSQ + NSTEP;

    logic en;
    logic [DEPTH-1:0] r_vld;

    // whole chain moves when the output slot is free or being taken
    assign en = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // ---- stage 1: nine component products ----
    logic signed [CW-1:0] qw, qx, qy, qz;
    assign qw = s_axis_tdata[0*CW +: CW];
    assign qx = s_axis_tdata[1*CW +: CW];
    assign qy = s_axis_tdata[2*CW +: CW];
    assign qz = s_axis_tdata[3*CW +: CW];

    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_wy <= qw * qy;
            r_zx <= qz * qx;
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_zz <= qz * qz;
        end
    end

    // product to work format, floor shift or left shift
    function automatic t_work to_work(input logic signed [PW-1:0] p);
        logic signed [PW+WW-1:0] e;
        e = (PW+WW)'(p);
        if (SH > 0) e = e >>> SH;
        else        e = e <<< (-SH);
        return e[WW-1:0];
    endfunction

    // ---- stage 2: atan2 operands and pitch sine ----
    localparam t_work ONE = t_work'(1) <<< WORK_FRAC;
    t_work r_sinr, r_cosr, r_siny, r_cosy, r_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sinr <= (to_work(r_wx) + to_work(r_yz)) <<< 1;
            r_cosr <= ONE - ((to_work(r_xx) + to_work(r_yy)) <<< 1);
            r_s    <= (to_work(r_wy) - to_work(r_zx)) <<< 1;
            r_siny <= (to_work(r_wz) + to_work(r_xy)) <<< 1;
            r_cosy <= ONE - ((to_work(r_yy) + to_work(r_zz)) <<< 1);
        end
    end

    // ---- pitch radicand 2^60 - s*s (zero when saturated, unused then) ----
    // unsaturated sine lies strictly inside +-2^30, so 31 bits square it
    logic signed [30:0]    s_lo;
    logic signed [61:0]    ssq;
    logic [SQW-1:0] rad;
    logic sat_s;
    assign sat_s = (r_s >= ONE) || (r_s <= -ONE);
    assign s_lo  = r_s[30:0];
    assign ssq   = s_lo * s_lo;
    assign rad   = sat_s ? '0 : (SQW'(1) << 60) - ssq;

    // ---- square root cell chain; roll/yaw lanes delayed alongside ----
    logic [SQW-1:0] sq_rem [NSQ+1];
    logic [SQW-1:0] sq_res [NSQ+1];
    t_work          sq_s   [NSQ+1];
    t_lane          dl_r   [NSQ+1];
    t_lane          dl_y   [NSQ+1];

    assign sq_rem[0] = rad;
    assign sq_res[0] = '0;
    assign sq_s[0]   = r_s;
    assign dl_r[0]   = lane_init(r_sinr, r_cosr);
    assign dl_y[0]   = lane_init(r_siny, r_cosy);

    genvar g;
    generate
        for (g = 0; g < NSQ; g++) begin : g_sq
            q2e_sqrt_cell #(.BIT(30 - g)) u_sq (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (sq_rem[g]),
                .i_res (sq_res[g]),
                .i_s   (sq_s[g]),
                .o_rem (sq_rem[g+1]),
                .o_res (sq_res[g+1]),
                .o_s   (sq_s[g+1])
            );
            always_ff @(posedge i_clk) begin
                if (en) begin
                    dl_r[g+1] <= dl_r[g];
                    dl_y[g+1] <= dl_y[g];
                end
            end
        end
    endgenerate

    // pitch lane; saturation handled after the chain via the carried sine
    t_work s_end;
    assign s_end = sq_s[NSQ];

    // ---- three CORDIC cell chains ----
    t_lane cr [NSTEP+1];
    t_lane cp [NSTEP+1];
    t_lane cy [NSTEP+1];
    t_work s_dl [NSTEP+1];

    assign cr[0]   = dl_r[NSQ];
    assign cy[0]   = dl_y[NSQ];
    assign cp[0]   = lane_init(s_end, t_work'(sq_res[NSQ]));
    assign s_dl[0] = s_end;

    generate
        for (g = 0; g < NSTEP; g++) begin : g_cd
            q2e_cordic_cell #(.STEP(g)) u_r (
                .i_clk(i_clk), .i_en(en), .i_lane(cr[g]), .o_lane(cr[g+1]));
            q2e_cordic_cell #(.STEP(g)) u_p (
                .i_clk(i_clk), .i_en(en), .i_lane(cp[g]), .o_lane(cp[g+1]));
            q2e_cordic_cell #(.STEP(g)) u_y (
                .i_clk(i_clk), .i_en(en), .i_lane(cy[g]), .o_lane(cy[g+1]));
            always_ff @(posedge i_clk) begin
                if (en) begin
                    s_dl[g+1] <= s_dl[g];
                end
            end
        end
    endgenerate

    // zero vector in: angle is defined as zero, cells would drift, so flag it
    logic zr [NSTEP+1];
    logic zy [NSTEP+1];
    logic zp [NSTEP+1];
    assign zr[0] = (cr[0].x == 0) && (cr[0].y == 0);
    assign zy[0] = (cy[0].x == 0) && (cy[0].y == 0);
    assign zp[0] = (cp[0].x == 0) && (cp[0].y == 0);
    generate
        for (g = 0; g < NSTEP; g++) begin : g_zf
            always_ff @(posedge i_clk) begin
                if (en) begin
                    zr[g+1] <= zr[g];
                    zy[g+1] <= zy[g];
                    zp[g+1] <= zp[g];
                end
            end
        end
    endgenerate

    // ---- output assembly ----
    logic [15:0] o_roll, o_pitch, o_yaw;
    t_work sf;
    assign sf      = s_dl[NSTEP];
    assign o_roll  = zr[NSTEP] ? 16'd0 : angle16(cr[NSTEP].z);
    assign o_yaw   = zy[NSTEP] ? 16'd0 : angle16(cy[NSTEP].z);
    assign o_pitch = (sf >= ONE)  ? 16'd16384 :
                     (sf <= -ONE) ? 16'hC000 :
                     zp[NSTEP]    ? 16'd0 : angle16(cp[NSTEP].z);

    logic [47:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {o_yaw, o_pitch, o_roll};
        end
    end

    assign m_axis_tdata  = r_out;
    assign m_axis_tvalid = r_vld[DEPTH-1];

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // ready follows the output slot
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    // pitch limited to a quarter turn
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= 16'sd16384 &&
                           $signed(m_axis_tdata[31:16]) >= -16'sd16384))
        else $error("pitch out of range");
endmodule
